// File: rtl/wfpa_pkg.sv
// shared types, widths and constants of the worst-fit page allocator
package wfpa_pkg;

  localparam int TAG_W   = 16;
  localparam int SIZE_W  = 24;
  localparam int PS_W    = 21;
  localparam int LEN_W   = 36;
  localparam int OUT_W   = 36;
  localparam int PAGES_W = 32;
  localparam int PG_ADD_W = SIZE_W + 1;

  localparam int DEF_MAX_PARTITIONS = 256;
  localparam int DEF_ADDR_BITS      = 36;

  localparam logic [PS_W-1:0] PAGE_SIZE_RESET = PS_W'(4096);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SC_RD,
    ST_SC_DT,
    ST_DECIDE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_GRAB,
    ST_BUILD,
    ST_WRITE,
    ST_MK_RD,
    ST_MK_DT,
    ST_MG_RD0,
    ST_MG_LD,
    ST_MG_RD,
    ST_MG_DT,
    ST_REP,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BR_SPLIT,
    BR_TAIL,
    BR_APPEND
  } branch_t;

  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] dividend;
    logic [PS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quo;
    logic [PS_W-1:0]   rem;
  } div_rsp_t;

endpackage

// File: rtl/wfpa_ram.sv
// generic single-write, single-read ram with registered read data
module wfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/wfpa_div.sv
// restoring divider, one quotient bit per cycle
module wfpa_div (
  input  logic                clk,
  input  logic                rst_n,
  input  wfpa_pkg::div_req_t  req,
  output wfpa_pkg::div_rsp_t  rsp
);
  import wfpa_pkg::*;

  localparam int CNT_W = $clog2(SIZE_W + 1);

  logic [PS_W-1:0]   rem_r, rem_nxt;
  logic [SIZE_W-1:0] quo_r, quo_nxt;
  logic [PS_W-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PS_W:0]     trial;
  logic [PS_W:0]     diff;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[SIZE_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CNT_W'(SIZE_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[PS_W-1:0];
        quo_nxt = {quo_r[SIZE_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[PS_W-1:0];
        quo_nxt = {quo_r[SIZE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/worst_fit_page_allocator.sv
// worst-fit page allocator: partition table in ram, walked by a small sequencer
// an allocation runs a worst-fit scan, the page divider when no free partition fits, a free-slot
//   search, the table writes and a report scan; a free runs a tag pass, a merge pass and a report
//   scan
// throughput: one beat at a time, bounded by the single ram read port walking the list
// reset (synchronous, active low): table empty, page count zero, page size 4096,
//   no clearing pass over the ram
module worst_fit_page_allocator #(
  parameter int MAX_PARTITIONS = wfpa_pkg::DEF_MAX_PARTITIONS,
  parameter int ADDR_BITS      = wfpa_pkg::DEF_ADDR_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [wfpa_pkg::TAG_W-1:0]     in_tag,
  input  logic [wfpa_pkg::SIZE_W-1:0]    in_size,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wfpa_pkg::OUT_W-1:0]     out_largest_free_size,
  output logic [wfpa_pkg::OUT_W-1:0]     out_largest_free_address,
  output logic [wfpa_pkg::PAGES_W-1:0]   out_pages_requested,
  output logic                           out_table_full,
  input  logic                           cfg_we,
  input  logic [wfpa_pkg::PS_W-1:0]      cfg_wdata
);
  import wfpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  // one table entry as it sits in the ram
  typedef struct packed {
    logic                 free;
    logic [TAG_W-1:0]     owner;
    logic [LEN_W-1:0]     len;
    logic [ADDR_BITS-1:0] start;
    logic [IDX_W-1:0]     nxt;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // start plus length, wrapping at the address width
  function automatic logic [ADDR_BITS-1:0] addr_add(input logic [ADDR_BITS-1:0] a,
                                                    input logic [LEN_W-1:0] l);
    logic [ADDR_BITS+LEN_W-1:0] t;
    t = (ADDR_BITS+LEN_W)'(a) + (ADDR_BITS+LEN_W)'(l);
    return t[ADDR_BITS-1:0];
  endfunction

  // sequencer and table bookkeeping
  state_t                state_r, state_nxt;
  logic                  rep_r, rep_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic                  full_r, full_nxt;
  logic [PS_W-1:0]       page_size_r, page_size_nxt;
  logic [PAGES_W-1:0]    page_total_r, page_total_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      last_r, last_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [MAX_PARTITIONS-1:0] in_use_r, in_use_nxt;

  // list walk
  logic [IDX_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;

  // best free partition seen and the last entry of the list
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [LEN_W-1:0]      best_len_r, best_len_nxt;
  logic [ADDR_BITS-1:0]  best_start_r, best_start_nxt;
  logic [IDX_W-1:0]      best_next_r, best_next_nxt;
  ent_t                  lst_r, lst_nxt;

  // allocation working values
  branch_t               br_r, br_nxt;
  logic [1:0]            nsl_r, nsl_nxt;
  logic [PG_ADD_W-1:0]   pages_r, pages_nxt;
  logic [LEN_W-1:0]      remt_r, remt_nxt;
  logic [SIZE_W-1:0]     dvd_r, dvd_nxt;
  logic [IDX_W-1:0]      s1_r, s1_nxt;
  logic [IDX_W-1:0]      s2_r, s2_nxt;
  logic [IDX_W-1:0]      gi_r, gi_nxt;
  logic [1:0]            gcnt_r, gcnt_nxt;

  // pending table writes
  logic [IDX_W-1:0]      wq_addr_r [3];
  logic [IDX_W-1:0]      wq_addr_nxt [3];
  ent_t                  wq_data_r [3];
  ent_t                  wq_data_nxt [3];
  logic [2:0]            wq_vld_r, wq_vld_nxt;
  logic [1:0]            wi_r, wi_nxt;

  // merge pass: current entry held in flops
  ent_t                  cur_r, cur_nxt;
  logic [IDX_W-1:0]      ci_r, ci_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      o_size_r, o_size_nxt;
  logic [OUT_W-1:0]      o_addr_r, o_addr_nxt;
  logic [PAGES_W-1:0]    o_pages_r, o_pages_nxt;
  logic                  o_full_r, o_full_nxt;

  // ram and divider hookup
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  ent_t                  mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ENT_W-1:0]      mem_rdata;
  ent_t                  rd_ent;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  // helpers
  logic [PS_W-1:0]            ps_eff;
  logic [LEN_W-1:0]           size_len;
  logic [LEN_W-1:0]           need_len;
  logic [ADDR_BITS-1:0]       st_app;
  logic [PAGES_W:0]           page_sum;
  logic [ADDR_BITS+OUT_W-1:0] addr_ext;
  logic                       out_free;

  assign rd_ent   = ent_t'(mem_rdata);
  assign ps_eff   = (page_size_r == '0) ? PS_W'(1) : page_size_r;
  assign size_len = LEN_W'(size_r);
  assign need_len = size_len - lst_r.len;
  assign st_app   = (used_r == '0) ? '0 : addr_add(lst_r.start, lst_r.len);
  assign page_sum = {1'b0, page_total_r} + (PAGES_W+1)'(pages_r);
  assign addr_ext = (ADDR_BITS+OUT_W)'(best_start_r);
  assign out_free = !out_valid_r || out_ready;

  wfpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_PARTITIONS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wfpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_FREE) begin
            state_nxt = (used_r == '0) ? ST_REP : ST_MK_RD;
          end else begin
            state_nxt = (used_r == '0) ? ST_DECIDE : ST_SC_RD;
          end
        end
      end
      ST_SC_RD:  state_nxt = ST_SC_DT;
      ST_SC_DT: begin
        if (k_r + 1'b1 == used_r) begin
          state_nxt = rep_r ? ST_OUT : ST_DECIDE;
        end else begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_DECIDE: begin
        if (found_r && best_len_r >= size_len) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_rsp.done) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (({1'b0, used_r} + (CNT_W+1)'(nsl_r)) > (CNT_W+1)'(MAX_PARTITIONS)) begin
          state_nxt = ST_REP;
        end else begin
          state_nxt = (nsl_r == 2'd0) ? ST_BUILD : ST_GRAB;
        end
      end
      ST_GRAB: begin
        if (!in_use_r[gi_r] && (gcnt_r + 2'd1 == nsl_r)) state_nxt = ST_BUILD;
      end
      ST_BUILD: state_nxt = ST_WRITE;
      ST_WRITE: if (wi_r == 2'd2) state_nxt = ST_REP;
      ST_MK_RD: state_nxt = ST_MK_DT;
      ST_MK_DT: state_nxt = (k_r + 1'b1 == used_r) ? ST_MG_RD0 : ST_MK_RD;
      ST_MG_RD0: state_nxt = (used_r <= CNT_W'(1)) ? ST_REP : ST_MG_LD;
      ST_MG_LD:  state_nxt = ST_MG_RD;
      ST_MG_RD:  state_nxt = (k_r > CNT_W'(1)) ? ST_MG_DT : ST_REP;
      ST_MG_DT:  state_nxt = ST_MG_RD;
      ST_REP:    state_nxt = (used_r == '0) ? ST_OUT : ST_SC_RD;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rep_nxt        = rep_r;
    tag_nxt        = tag_r;
    size_nxt       = size_r;
    full_nxt       = full_r;
    page_size_nxt  = cfg_we ? cfg_wdata : page_size_r;
    page_total_nxt = page_total_r;
    head_nxt       = head_r;
    last_nxt       = last_r;
    used_nxt       = used_r;
    in_use_nxt     = in_use_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    best_next_nxt  = best_next_r;
    lst_nxt        = lst_r;
    br_nxt         = br_r;
    nsl_nxt        = nsl_r;
    pages_nxt      = pages_r;
    remt_nxt       = remt_r;
    dvd_nxt        = dvd_r;
    s1_nxt         = s1_r;
    s2_nxt         = s2_r;
    gi_nxt         = gi_r;
    gcnt_nxt       = gcnt_r;
    wq_addr_nxt    = wq_addr_r;
    wq_data_nxt    = wq_data_r;
    wq_vld_nxt     = wq_vld_r;
    wi_nxt         = wi_r;
    cur_nxt        = cur_r;
    ci_nxt         = ci_r;
    out_valid_nxt  = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    o_size_nxt     = o_size_r;
    o_addr_nxt     = o_addr_r;
    o_pages_nxt    = o_pages_r;
    o_full_nxt     = o_full_r;
    mem_we         = 1'b0;
    mem_waddr      = i_r;
    mem_wdata      = rd_ent;
    mem_raddr      = i_r;
    div_req.start    = 1'b0;
    div_req.dividend = dvd_r;
    div_req.divisor  = ps_eff;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tag_nxt   = in_tag;
          size_nxt  = in_size;
          full_nxt  = 1'b0;
          rep_nxt   = 1'b0;
          found_nxt = 1'b0;
          i_nxt     = head_r;
          k_nxt     = '0;
        end
      end

      // worst-fit scan, strict compare keeps the lowest address on ties
      ST_SC_DT: begin
        if (rd_ent.free && (!found_r || rd_ent.len > best_len_r)) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = i_r;
          best_len_nxt   = rd_ent.len;
          best_start_nxt = rd_ent.start;
          best_next_nxt  = rd_ent.nxt;
        end
        if (k_r + 1'b1 == used_r) lst_nxt = rd_ent;
        i_nxt = rd_ent.nxt;
        k_nxt = k_r + 1'b1;
      end

      ST_DECIDE: begin
        if (found_r && best_len_r >= size_len) begin
          br_nxt   = BR_SPLIT;
          remt_nxt = best_len_r - size_len;
          nsl_nxt  = (best_len_r != size_len) ? 2'd1 : 2'd0;
        end else if (used_r != '0 && lst_r.free) begin
          // free last partition is absorbed, only the shortfall needs pages
          br_nxt  = BR_TAIL;
          dvd_nxt = need_len[SIZE_W-1:0];
        end else begin
          br_nxt  = BR_APPEND;
          dvd_nxt = size_r;
        end
      end

      ST_DIV_GO: div_req.start = 1'b1;

      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          // pages rounded up; the unused rest of the last page becomes a free tail
          pages_nxt = PG_ADD_W'(div_rsp.quo) + PG_ADD_W'(div_rsp.rem != '0);
          remt_nxt  = (div_rsp.rem != '0) ? LEN_W'(ps_eff - div_rsp.rem) : '0;
          if (br_r == BR_APPEND) begin
            nsl_nxt = (div_rsp.rem != '0) ? 2'd2 : 2'd1;
          end else begin
            nsl_nxt = (div_rsp.rem != '0) ? 2'd1 : 2'd0;
          end
        end
      end

      ST_CHECK: begin
        if (({1'b0, used_r} + (CNT_W+1)'(nsl_r)) > (CNT_W+1)'(MAX_PARTITIONS)) begin
          full_nxt = 1'b1;
        end else if (br_r != BR_SPLIT) begin
          page_total_nxt = page_sum[PAGES_W] ? '1 : page_sum[PAGES_W-1:0];
        end
        gi_nxt   = '0;
        gcnt_nxt = '0;
      end

      // lowest unused slots, one candidate a cycle
      ST_GRAB: begin
        if (!in_use_r[gi_r]) begin
          in_use_nxt[gi_r] = 1'b1;
          if (gcnt_r == 2'd0) s1_nxt = gi_r;
          else                s2_nxt = gi_r;
          gcnt_nxt = gcnt_r + 2'd1;
        end
        gi_nxt = gi_r + 1'b1;
      end

      ST_BUILD: begin
        wi_nxt   = '0;
        used_nxt = used_r + CNT_W'(nsl_r);
        case (br_r)
          BR_SPLIT: begin
            wq_vld_nxt     = {1'b0, 1'b1, nsl_r != 2'd0};
            wq_addr_nxt[0] = s1_r;
            wq_data_nxt[0] = '{free: 1'b1, owner: '0, len: remt_r,
                               start: addr_add(best_start_r, size_len), nxt: best_next_r};
            wq_addr_nxt[1] = best_idx_r;
            wq_data_nxt[1] = '{free: 1'b0, owner: tag_r, len: size_len, start: best_start_r,
                               nxt: (nsl_r != 2'd0) ? s1_r : best_next_r};
            if (last_r == best_idx_r && nsl_r != 2'd0) last_nxt = s1_r;
          end
          BR_TAIL: begin
            wq_vld_nxt     = {1'b0, nsl_r != 2'd0, 1'b1};
            wq_addr_nxt[0] = last_r;
            wq_data_nxt[0] = '{free: 1'b0, owner: tag_r, len: size_len, start: lst_r.start,
                               nxt: (nsl_r != 2'd0) ? s1_r : lst_r.nxt};
            wq_addr_nxt[1] = s1_r;
            wq_data_nxt[1] = '{free: 1'b1, owner: '0, len: remt_r,
                               start: addr_add(lst_r.start, size_len), nxt: '0};
            if (nsl_r != 2'd0) last_nxt = s1_r;
          end
          default: begin
            wq_vld_nxt     = {nsl_r == 2'd2, used_r != '0, 1'b1};
            wq_addr_nxt[0] = s1_r;
            wq_data_nxt[0] = '{free: 1'b0, owner: tag_r, len: size_len, start: st_app,
                               nxt: (nsl_r == 2'd2) ? s2_r : '0};
            wq_addr_nxt[1] = last_r;
            wq_data_nxt[1] = lst_r;
            wq_data_nxt[1].nxt = s1_r;
            wq_addr_nxt[2] = s2_r;
            wq_data_nxt[2] = '{free: 1'b1, owner: '0, len: remt_r,
                               start: addr_add(st_app, size_len), nxt: '0};
            if (used_r == '0) head_nxt = s1_r;
            last_nxt = (nsl_r == 2'd2) ? s2_r : s1_r;
          end
        endcase
      end

      ST_WRITE: begin
        mem_we    = wq_vld_r[wi_r];
        mem_waddr = wq_addr_r[wi_r];
        mem_wdata = wq_data_r[wi_r];
        wi_nxt    = wi_r + 2'd1;
      end

      // release pass: every owned partition of the tag turns free
      ST_MK_DT: begin
        if (!rd_ent.free && rd_ent.owner == tag_r) begin
          mem_we         = 1'b1;
          mem_waddr      = i_r;
          mem_wdata      = rd_ent;
          mem_wdata.free = 1'b1;
        end
        i_nxt = rd_ent.nxt;
        k_nxt = k_r + 1'b1;
      end

      ST_MG_RD0: begin
        mem_raddr = head_r;
        ci_nxt    = head_r;
        k_nxt     = used_r;
      end

      ST_MG_LD: cur_nxt = rd_ent;

      ST_MG_RD: mem_raddr = cur_r.nxt;

      // coalesce the held entry with its successor when both are free
      ST_MG_DT: begin
        if (cur_r.free && rd_ent.free) begin
          cur_nxt.len = cur_r.len + rd_ent.len;
          cur_nxt.nxt = rd_ent.nxt;
          mem_we      = 1'b1;
          mem_waddr   = ci_r;
          mem_wdata   = cur_r;
          mem_wdata.len = cur_r.len + rd_ent.len;
          mem_wdata.nxt = rd_ent.nxt;
          in_use_nxt[cur_r.nxt] = 1'b0;
          if (last_r == cur_r.nxt) last_nxt = ci_r;
          used_nxt = used_r - 1'b1;
        end else begin
          ci_nxt  = cur_r.nxt;
          cur_nxt = rd_ent;
        end
        k_nxt = k_r - 1'b1;
      end

      ST_REP: begin
        rep_nxt   = 1'b1;
        found_nxt = 1'b0;
        i_nxt     = head_r;
        k_nxt     = '0;
      end

      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_size_nxt    = found_r ? OUT_W'(best_len_r) : '0;
          o_addr_nxt    = found_r ? addr_ext[OUT_W-1:0] : '0;
          o_pages_nxt   = page_total_r;
          o_full_nxt    = full_r;
        end
      end

      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      page_size_r  <= PAGE_SIZE_RESET;
      page_total_r <= '0;
      head_r       <= '0;
      last_r       <= '0;
      used_r       <= '0;
      in_use_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      page_size_r  <= page_size_nxt;
      page_total_r <= page_total_nxt;
      head_r       <= head_nxt;
      last_r       <= last_nxt;
      used_r       <= used_nxt;
      in_use_r     <= in_use_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working values and result payload
  always_ff @(posedge clk) begin
    rep_r        <= rep_nxt;
    tag_r        <= tag_nxt;
    size_r       <= size_nxt;
    full_r       <= full_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_len_r   <= best_len_nxt;
    best_start_r <= best_start_nxt;
    best_next_r  <= best_next_nxt;
    lst_r        <= lst_nxt;
    br_r         <= br_nxt;
    nsl_r        <= nsl_nxt;
    pages_r      <= pages_nxt;
    remt_r       <= remt_nxt;
    dvd_r        <= dvd_nxt;
    s1_r         <= s1_nxt;
    s2_r         <= s2_nxt;
    gi_r         <= gi_nxt;
    gcnt_r       <= gcnt_nxt;
    wq_addr_r    <= wq_addr_nxt;
    wq_data_r    <= wq_data_nxt;
    wq_vld_r     <= wq_vld_nxt;
    wi_r         <= wi_nxt;
    cur_r        <= cur_nxt;
    ci_r         <= ci_nxt;
    o_size_r     <= o_size_nxt;
    o_addr_r     <= o_addr_nxt;
    o_pages_r    <= o_pages_nxt;
    o_full_r     <= o_full_nxt;
  end

  assign in_ready                 = (state_r == ST_IDLE);
  assign out_valid                = out_valid_r;
  assign out_largest_free_size    = o_size_r;
  assign out_largest_free_address = o_addr_r;
  assign out_pages_requested      = o_pages_r;
  assign out_table_full           = o_full_r;

endmodule
